>>> sv/midpoint_circle_rasterizer_core_assert.svh
// Assertion macros for the midpoint circle rasterizer checker.
// Every macro samples on i_clk and is held off while i_rst_n is low.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_CORE_ASSERT_SVH

// A property that must hold at every edge outside reset.
`define MCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition at one edge that implies another at the next edge.
`define MCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mcr_pkg.sv
// Shared constants for the midpoint circle rasterizer.
// Field widths of the request and result beats and default grid sizes.
package mcr_pkg;

    localparam int MCR_GRID_WIDTH  = 16;
    localparam int MCR_GRID_HEIGHT = 16;
    localparam int MCR_MAX_RADIUS  = 16;

    localparam int CXY_W   = 4;
    localparam int RAD_W   = 6;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 8;
    localparam int LANES   = 8;

endpackage

>>> sv/mcr_step.sv
// Decision step of the midpoint circle loop: one shared adder updates the
// error term, and the offsets advance. Depends on mcr_pkg.
module mcr_step
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = MCR_MAX_RADIUS
) (
    input  logic [$clog2(MAX_RADIUS + 1)-1:0]        i_a,
    input  logic [$clog2(MAX_RADIUS + 2)-1:0]        i_b,
    input  logic signed [$clog2(MAX_RADIUS + 2)+2:0] i_err,
    output logic [$clog2(MAX_RADIUS + 1)-1:0]        o_a,
    output logic [$clog2(MAX_RADIUS + 2)-1:0]        o_b,
    output logic signed [$clog2(MAX_RADIUS + 2)+2:0] o_err,
    output logic                                     o_last
);

    localparam int A_W = $clog2(MAX_RADIUS + 1);
    localparam int B_W = $clog2(MAX_RADIUS + 2);
    localparam int E_W = B_W + 3;

    logic                  neg;
    logic [A_W-1:0]        a1;
    logic [B_W-1:0]        b1;
    logic signed [E_W-1:0] a1_e;
    logic signed [E_W-1:0] b1_e;
    logic signed [E_W-1:0] addend;

    always_comb begin
        neg  = i_err[E_W-1];
        b1   = i_b + B_W'(1);
        a1   = neg ? i_a : i_a - A_W'(1);
        a1_e = $signed(E_W'(a1));
        b1_e = $signed(E_W'(b1));
        if (neg) begin
            addend = (b1_e <<< 1) + $signed(E_W'(1));
        end else begin
            addend = (b1_e - a1_e + $signed(E_W'(1))) <<< 1;
        end
        o_a    = a1;
        o_b    = b1;
        o_err  = i_err + addend;
        o_last = B_W'(a1) < b1;
    end

endmodule

>>> sv/mcr_point.sv
// Eight octant lanes: mirrored points, on-grid test and row-major index.
// Off-grid points read as zero. Depends on mcr_pkg.
module mcr_point
    import mcr_pkg::*;
#(
    parameter int GRID_WIDTH  = MCR_GRID_WIDTH,
    parameter int GRID_HEIGHT = MCR_GRID_HEIGHT,
    parameter int MAX_RADIUS  = MCR_MAX_RADIUS
) (
    input  logic [CXY_W-1:0]                   i_cx,
    input  logic [CXY_W-1:0]                   i_cy,
    input  logic [$clog2(MAX_RADIUS + 1)-1:0]  i_a,
    input  logic [$clog2(MAX_RADIUS + 2)-1:0]  i_b,
    output logic [PIX_W-1:0]                   o_pix [LANES],
    output logic [LANES-1:0]                   o_mask
);

    localparam int B_W   = $clog2(MAX_RADIUS + 2);
    localparam int C_W   = ((B_W > CXY_W) ? B_W : CXY_W) + 2;
    localparam int IDX_W = 16;

    logic signed [C_W-1:0] cx_s;
    logic signed [C_W-1:0] cy_s;
    logic signed [C_W-1:0] a_s;
    logic signed [C_W-1:0] b_s;

    assign cx_s = $signed(C_W'(i_cx));
    assign cy_s = $signed(C_W'(i_cy));
    assign a_s  = $signed(C_W'(i_a));
    assign b_s  = $signed(C_W'(i_b));

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        localparam bit SWAP = (i % 2) == 1;
        localparam bit XNEG = (i >= 2) && (i <= 5);
        localparam bit YNEG = (i >= 4);

        logic signed [C_W-1:0] dx;
        logic signed [C_W-1:0] dy;
        logic signed [C_W-1:0] x;
        logic signed [C_W-1:0] y;
        logic                  vis;
        logic [IDX_W-1:0]      idx;

        always_comb begin
            dx  = SWAP ? b_s : a_s;
            dy  = SWAP ? a_s : b_s;
            x   = XNEG ? cx_s - dx : cx_s + dx;
            y   = YNEG ? cy_s - dy : cy_s + dy;
            vis = (int'(x) >= 0) && (int'(x) < GRID_WIDTH) &&
                  (int'(y) >= 0) && (int'(y) < GRID_HEIGHT);
            idx = IDX_W'($unsigned(y)) * IDX_W'(GRID_WIDTH) + IDX_W'($unsigned(x));
            o_pix[i]  = vis ? idx[PIX_W-1:0] : '0;
            o_mask[i] = vis;
        end
    end

endmodule

>>> sv/midpoint_circle_rasterizer_core.sv
// Top level of the midpoint circle rasterizer: sequencer, loop registers,
// output register. Depends on mcr_pkg, mcr_step and mcr_point.
//
//  channel  | direction | valid        | stall       | beat
//  request  | in        | i_in_valid   | o_in_stall  | center, radius, color
//  result   | out       | o_out_valid  | i_out_stall | eight pixels, mask, color, last
//
// A circle of radius r gives about r/sqrt(2)+1 beats, one per cycle through the
// decision adder while the result is not stalled.
// A negative or zero radius gives one beat.
// Reset is synchronous and clears the sequencer and the result valid.
// A stalled result holds the loop; the request side stalls until the last beat
// of the circle is in the output register.
module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
#(
    parameter int GRID_WIDTH  = MCR_GRID_WIDTH,
    parameter int GRID_HEIGHT = MCR_GRID_HEIGHT,
    parameter int MAX_RADIUS  = MCR_MAX_RADIUS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CXY_W-1:0]        i_center_x,
    input  logic [CXY_W-1:0]        i_center_y,
    input  logic signed [RAD_W-1:0] i_radius,
    input  logic [COLOR_W-1:0]      i_draw_color,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [PIX_W-1:0]        o_pixel_0,
    output logic [PIX_W-1:0]        o_pixel_1,
    output logic [PIX_W-1:0]        o_pixel_2,
    output logic [PIX_W-1:0]        o_pixel_3,
    output logic [PIX_W-1:0]        o_pixel_4,
    output logic [PIX_W-1:0]        o_pixel_5,
    output logic [PIX_W-1:0]        o_pixel_6,
    output logic [PIX_W-1:0]        o_pixel_7,
    output logic [LANES-1:0]        o_visible_mask,
    output logic [COLOR_W-1:0]      o_paint_color,
    output logic                    o_last
);

    localparam int A_W = $clog2(MAX_RADIUS + 1);
    localparam int B_W = $clog2(MAX_RADIUS + 2);
    localparam int E_W = B_W + 3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef enum logic [1:0] {
        M_CIRCLE,
        M_DOT,
        M_EMPTY
    } t_mode;

    t_state                r_state;
    t_state                n_state;
    t_mode                 r_mode;
    logic [A_W-1:0]        r_a;
    logic [B_W-1:0]        r_b;
    logic signed [E_W-1:0] r_err;
    logic [CXY_W-1:0]      r_cx;
    logic [CXY_W-1:0]      r_cy;
    logic [COLOR_W-1:0]    r_color;

    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_pix [LANES];
    logic [LANES-1:0]      r_mask;
    logic [COLOR_W-1:0]    r_out_color;
    logic                  r_out_last;

    logic                  in_take;
    logic                  out_free;
    logic                  emit;
    logic                  emit_last;
    logic [LANES-1:0]      emit_mask;
    logic                  sat;
    logic [A_W-1:0]        start_a;

    logic [A_W-1:0]        step_a;
    logic [B_W-1:0]        step_b;
    logic signed [E_W-1:0] step_err;
    logic                  step_last;
    logic [PIX_W-1:0]      pt_pix [LANES];
    logic [LANES-1:0]      pt_mask;

    mcr_step #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_step (
        .i_a    (r_a),
        .i_b    (r_b),
        .i_err  (r_err),
        .o_a    (step_a),
        .o_b    (step_b),
        .o_err  (step_err),
        .o_last (step_last)
    );

    mcr_point #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .MAX_RADIUS  (MAX_RADIUS)
    ) u_point (
        .i_cx   (r_cx),
        .i_cy   (r_cy),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_pix  (pt_pix),
        .o_mask (pt_mask)
    );

    always_comb begin
        in_take  = (r_state == S_IDLE) && i_in_valid;
        out_free = !r_out_valid || !i_out_stall;
        emit     = (r_state == S_RUN) && out_free;
        sat      = int'(i_radius) > MAX_RADIUS;
        start_a  = sat ? A_W'(MAX_RADIUS) : A_W'(i_radius[RAD_W-2:0]);
        case (r_mode)
            M_CIRCLE: begin
                emit_mask = pt_mask;
                emit_last = step_last;
            end
            M_DOT: begin
                emit_mask = {{(LANES - 1){1'b0}}, pt_mask[0]};
                emit_last = 1'b1;
            end
            default: begin
                emit_mask = '0;
                emit_last = 1'b1;
            end
        endcase
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (emit && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_color <= i_draw_color;
            r_b     <= '0;
            if (i_radius[RAD_W-1]) begin
                r_mode <= M_EMPTY;
                r_a    <= '0;
            end else if (i_radius == '0) begin
                r_mode <= M_DOT;
                r_a    <= '0;
            end else begin
                r_mode <= M_CIRCLE;
                r_a    <= start_a;
            end
            r_err <= $signed(E_W'(1)) - $signed(E_W'(start_a));
        end else if (emit) begin
            r_a   <= step_a;
            r_b   <= step_b;
            r_err <= step_err;
        end
        if (emit) begin
            for (int i = 0; i < LANES; i++) begin
                r_pix[i] <= emit_mask[i] ? pt_pix[i] : '0;
            end
            r_mask      <= emit_mask;
            r_out_color <= r_color;
            r_out_last  <= emit_last;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_pixel_0      = r_pix[0];
    assign o_pixel_1      = r_pix[1];
    assign o_pixel_2      = r_pix[2];
    assign o_pixel_3      = r_pix[3];
    assign o_pixel_4      = r_pix[4];
    assign o_pixel_5      = r_pix[5];
    assign o_pixel_6      = r_pix[6];
    assign o_pixel_7      = r_pix[7];
    assign o_visible_mask = r_mask;
    assign o_paint_color  = r_out_color;
    assign o_last         = r_out_last;

endmodule

>>> sv/mcr_checker.sv
// Port-level checks for the midpoint circle rasterizer, bound to the top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer_core_assert.svh.
`include "midpoint_circle_rasterizer_core_assert.svh"

module mcr_checker
    import mcr_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [PIX_W-1:0]        o_pixel_0,
    input logic [PIX_W-1:0]        o_pixel_1,
    input logic [PIX_W-1:0]        o_pixel_2,
    input logic [PIX_W-1:0]        o_pixel_3,
    input logic [PIX_W-1:0]        o_pixel_4,
    input logic [PIX_W-1:0]        o_pixel_5,
    input logic [PIX_W-1:0]        o_pixel_6,
    input logic [PIX_W-1:0]        o_pixel_7,
    input logic [LANES-1:0]        o_visible_mask,
    input logic [COLOR_W-1:0]      o_paint_color,
    input logic                    o_last
);

    logic [LANES*PIX_W+LANES+COLOR_W:0] beat;
    logic [LANES-1:0]                   clip_ok;

    assign beat = {o_pixel_7, o_pixel_6, o_pixel_5, o_pixel_4, o_pixel_3, o_pixel_2,
                   o_pixel_1, o_pixel_0, o_visible_mask, o_paint_color, o_last};
    assign clip_ok = o_visible_mask |
                     {(o_pixel_7 == '0), (o_pixel_6 == '0), (o_pixel_5 == '0),
                      (o_pixel_4 == '0), (o_pixel_3 == '0), (o_pixel_2 == '0),
                      (o_pixel_1 == '0), (o_pixel_0 == '0)};

    // A stalled result beat stays in place.
    `MCR_ASSERT_NEXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(beat), "stalled result beat changed")

    // A taken request stalls the request side.
    `MCR_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall, "request side open after accept")

    // The request side opens again only once the last beat of a circle is shown.
    `MCR_ASSERT(a_open, $fell(o_in_stall) && $past(i_rst_n) |-> o_out_valid && o_last, "early open")

    // A clipped point has a zero pixel index.
    `MCR_ASSERT(a_clip, o_out_valid |-> &clip_ok, "clipped point has a nonzero index")

endmodule

bind midpoint_circle_rasterizer_core mcr_checker u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pixel_0      (o_pixel_0),
    .o_pixel_1      (o_pixel_1),
    .o_pixel_2      (o_pixel_2),
    .o_pixel_3      (o_pixel_3),
    .o_pixel_4      (o_pixel_4),
    .o_pixel_5      (o_pixel_5),
    .o_pixel_6      (o_pixel_6),
    .o_pixel_7      (o_pixel_7),
    .o_visible_mask (o_visible_mask),
    .o_paint_color  (o_paint_color),
    .o_last         (o_last)
);
